// ===== rtl/lsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the LRU slot cache with budgets.
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int SLOT_COUNT = 5;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_ADDR_W = 4;

  // result status codes
  localparam logic [2:0] STS_INVALID   = 3'd0;
  localparam logic [2:0] STS_NOT_INIT  = 3'd1;
  localparam logic [2:0] STS_FAILED    = 3'd2;
  localparam logic [2:0] STS_HIT       = 3'd3;
  localparam logic [2:0] STS_LOADED    = 3'd4;
  localparam logic [2:0] STS_LOAD_FAIL = 3'd5;

  typedef enum logic [1:0] {
    REG_ENABLED    = 2'd0,
    REG_MAX_LOADED = 2'd1,
    REG_MAX_BYTES  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_TRIM,
    ST_SCAN,
    ST_EVICT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic        ready;
    logic        failed;
    logic [31:0] last_use;
    logic [23:0] index_size;
    logic        fast;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_addr;
  } mem_req_t;

  typedef struct packed {
    logic        enabled;
    logic [4:0]  max_loaded;
    logic [23:0] max_index_bytes;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/lsc_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_cfg_regs
// APB register file: enable, loaded-slot limit and fast-memory byte budget.
// ----------------------------------------------------------------------------
module lsc_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [lsc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                   cfg_pwdata,
  output logic      [31:0]                   cfg_prdata,
  output logic                               cfg_pready,
  output lsc_pkg::cfg_t                      cfg
);
  import lsc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[3:2])
        REG_ENABLED:    cfg_nxt.enabled         = cfg_pwdata[0];
        REG_MAX_LOADED: cfg_nxt.max_loaded      = cfg_pwdata[4:0];
        REG_MAX_BYTES:  cfg_nxt.max_index_bytes = cfg_pwdata[23:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      REG_ENABLED:    cfg_prdata = {31'd0, cfg_r.enabled};
      REG_MAX_LOADED: cfg_prdata = {27'd0, cfg_r.max_loaded};
      REG_MAX_BYTES:  cfg_prdata = {8'd0, cfg_r.max_index_bytes};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled         <= 1'b0;
      cfg_r.max_loaded      <= 5'd1;
      cfg_r.max_index_bytes <= 24'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lsc_slot_mem.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lsc_slot_mem
// Slot record memory, registered read, with per-entry valid bits
// so that an entry not written since reset or since its drop reads as zero.
// ----------------------------------------------------------------------------
module lsc_slot_mem (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lsc_pkg::mem_req_t  req,
  input  wire lsc_pkg::entry_t    wr_data,
  output lsc_pkg::entry_t         rd_data
);
  import lsc_pkg::*;

  entry_t                mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid_r;
  logic [SLOT_COUNT-1:0] valid_nxt;
  entry_t                rd_data_r;
  logic                  rd_valid_r;

  always_comb begin
    valid_nxt = valid_r;
    if (req.wr_en) begin
      valid_nxt[req.wr_addr] = 1'b1;
    end
    if (req.clr_en) begin
      valid_nxt[req.clr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule
`default_nettype wire

// ===== rtl/lru_slot_cache_with_budgets_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lru_slot_cache_with_budgets_top
// LRU slot cache: hit/load/fail handling per access, then LRU eviction while
// the loaded-count limit or the fast-memory byte budget is exceeded.
// ----------------------------------------------------------------------------
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid/in_tready    | in_tdata: access beat
//  out_    | out | out_tvalid/out_tready  | out_tdata: result beat
//  cfg_    | in  | APB psel/penable       | 32-bit registers at 0x0, 0x4, 0x8
//
//  One access at a time. A rejected or failed access goes from LOOKUP to FINISH;
//  a hit or load also passes TRIM, and each eviction adds a SCAN and an EVICT step:
//  one pass over the slot memory reading one entry per cycle to find the victim.
//  A pass that finds no victim ends the access.
//  Synchronous active-low reset clears the valid bits; no clearing pass.
//  in_tready drops while an access is in flight. A stalled result waits in
//  the output register; the next beat is taken and worked up to the finish
//  state, where it holds until the output register frees.
// ----------------------------------------------------------------------------
module lru_slot_cache_with_budgets_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // slot_number[3:0], load_ok[4], load_index_bytes[28:5], load_in_fast_memory[29]
  input  wire logic [lsc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // status[2:0], evicted_mask[18:3], loaded_count[23:19],
  // loaded_fast_bytes[51:24], still_over_budget[52]
  output logic      [lsc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_psel,
  input  wire logic                           cfg_penable,
  input  wire logic                           cfg_pwrite,
  input  wire logic [lsc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                    cfg_pwdata,
  output logic      [31:0]                    cfg_prdata,
  output logic                                cfg_pready
);
  import lsc_pkg::*;

  localparam logic [SLOT_COUNT-1:0] MASK_ONE  = SLOT_COUNT'(1);
  localparam logic [SLOT_W-1:0]     LAST_IDX  = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [4:0]            SLOT_CNT5 = 5'(SLOT_COUNT);

  cfg_t     cfg;
  mem_req_t req;
  entry_t   wr_data;
  entry_t   rd_data;

  state_t                state_r, state_nxt;
  logic [3:0]            slot_r, slot_nxt;
  logic                  ok_r, ok_nxt;
  logic [23:0]           bytes_r, bytes_nxt;
  logic                  fastin_r, fastin_nxt;
  logic [31:0]           clock_r, clock_nxt;
  logic [4:0]            count_r, count_nxt;
  logic [27:0]           fbytes_r, fbytes_nxt;
  logic [SLOT_COUNT-1:0] mask_r, mask_nxt;
  logic [2:0]            status_r, status_nxt;
  logic                  over_r, over_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic                  found_r, found_nxt;
  logic [31:0]           oldest_r, oldest_nxt;
  logic [SLOT_W-1:0]     victim_r, victim_nxt;
  logic [23:0]           vsize_r, vsize_nxt;
  logic                  vfast_r, vfast_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic              in_slot_ok;
  logic              slot_ok;
  logic [SLOT_W-1:0] slot_idx;
  logic [31:0]       clock_inc;
  logic [31:0]       clock_bump;
  logic [4:0]        limit;
  logic              over_limit;
  logic              cand;
  logic              better;

  lsc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lsc_slot_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign in_slot_ok = {1'b0, in_tdata[3:0]} < SLOT_CNT5;
  assign slot_ok    = {1'b0, slot_r} < SLOT_CNT5;
  assign slot_idx   = slot_r[SLOT_W-1:0];

  // use clock never lands on zero after a wrap
  assign clock_inc  = clock_r + 32'd1;
  assign clock_bump = (clock_inc == 32'd0) ? 32'd1 : clock_inc;

  assign limit      = (cfg.max_loaded == 5'd0) ? 5'd1 : cfg.max_loaded;
  assign over_limit = (count_r > limit) || (fbytes_r > {4'd0, cfg.max_index_bytes});

  assign cand   = rd_data.ready && (idx_r != slot_idx);
  assign better = cand && (!found_r || (rd_data.last_use < oldest_r));

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    ok_nxt        = ok_r;
    bytes_nxt     = bytes_r;
    fastin_nxt    = fastin_r;
    clock_nxt     = clock_r;
    count_nxt     = count_r;
    fbytes_nxt    = fbytes_r;
    mask_nxt      = mask_r;
    status_nxt    = status_r;
    over_nxt      = over_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    oldest_nxt    = oldest_r;
    victim_nxt    = victim_r;
    vsize_nxt     = vsize_r;
    vfast_nxt     = vfast_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    req           = '0;
    wr_data       = rd_data;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          slot_nxt    = in_tdata[3:0];
          ok_nxt      = in_tdata[4];
          bytes_nxt   = in_tdata[28:5];
          fastin_nxt  = in_tdata[29];
          mask_nxt    = '0;
          over_nxt    = 1'b0;
          req.rd_en   = in_slot_ok;
          req.rd_addr = in_tdata[SLOT_W-1:0];
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        req.wr_addr = slot_idx;
        if (!slot_ok) begin
          status_nxt = STS_INVALID;
          state_nxt  = ST_FINISH;
        end else if (!cfg.enabled) begin
          status_nxt = STS_NOT_INIT;
          state_nxt  = ST_FINISH;
        end else if (rd_data.failed) begin
          status_nxt = STS_FAILED;
          state_nxt  = ST_FINISH;
        end else if (rd_data.ready) begin
          clock_nxt        = clock_bump;
          req.wr_en        = 1'b1;
          wr_data.last_use = clock_bump;
          status_nxt       = STS_HIT;
          state_nxt        = ST_TRIM;
        end else if (ok_r) begin
          clock_nxt  = clock_bump;
          req.wr_en  = 1'b1;
          wr_data    = '{ready: 1'b1, failed: 1'b0, last_use: clock_bump,
                         index_size: bytes_r, fast: fastin_r};
          count_nxt  = count_r + 5'd1;
          fbytes_nxt = fastin_r ? (fbytes_r + 28'(bytes_r)) : fbytes_r;
          status_nxt = STS_LOADED;
          state_nxt  = ST_TRIM;
        end else begin
          req.wr_en  = 1'b1;
          wr_data    = '{ready: 1'b0, failed: 1'b1, last_use: 32'd0,
                         index_size: 24'd0, fast: 1'b0};
          status_nxt = STS_LOAD_FAIL;
          state_nxt  = ST_FINISH;
        end
      end
      ST_TRIM: begin
        if (over_limit) begin
          req.rd_en   = 1'b1;
          req.rd_addr = '0;
          idx_nxt     = '0;
          found_nxt   = 1'b0;
          state_nxt   = ST_SCAN;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (better) begin
          found_nxt  = 1'b1;
          oldest_nxt = rd_data.last_use;
          victim_nxt = idx_r;
          vsize_nxt  = rd_data.index_size;
          vfast_nxt  = rd_data.fast;
        end
        if (idx_r != LAST_IDX) begin
          req.rd_en   = 1'b1;
          req.rd_addr = idx_r + SLOT_W'(1);
          idx_nxt     = idx_r + SLOT_W'(1);
        end else if (found_r || better) begin
          state_nxt = ST_EVICT;
        end else begin
          // limits still exceeded and nothing left to drop
          over_nxt  = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_EVICT: begin
        req.clr_en   = 1'b1;
        req.clr_addr = victim_r;
        count_nxt    = count_r - 5'd1;
        fbytes_nxt   = vfast_r ? (fbytes_r - 28'(vsize_r)) : fbytes_r;
        mask_nxt     = mask_r | (MASK_ONE << victim_r);
        state_nxt    = ST_TRIM;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'd0, over_r, fbytes_r, count_r, 16'(mask_r), status_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      clock_r     <= 32'd0;
      count_r     <= 5'd0;
      fbytes_r    <= 28'd0;
      out_valid_r <= 1'b0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clock_r     <= clock_nxt;
      count_r     <= count_nxt;
      fbytes_r    <= fbytes_nxt;
      out_valid_r <= out_valid_nxt;
      found_r     <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    ok_r       <= ok_nxt;
    bytes_r    <= bytes_nxt;
    fastin_r   <= fastin_nxt;
    mask_r     <= mask_nxt;
    status_r   <= status_nxt;
    over_r     <= over_nxt;
    idx_r      <= idx_nxt;
    oldest_r   <= oldest_nxt;
    victim_r   <= victim_nxt;
    vsize_r    <= vsize_nxt;
    vfast_r    <= vfast_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTH
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SLOT_CNT5)
    else $error("loaded count above slot count");

  a_victim_not_keep : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVICT) |-> (found_r && (victim_r != slot_idx)))
    else $error("eviction without victim or of the accessed slot");

  a_evict_drops_count : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVICT) |=> (count_r == $past(count_r) - 5'd1))
    else $error("eviction did not drop the loaded count");

  a_evict_only_on_use : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !out_valid_r && ((mask_r != '0) || over_r)) |->
      ((status_r == STS_HIT) || (status_r == STS_LOADED)))
    else $error("eviction reported for a rejected or failed access");
`endif

endmodule
`default_nettype wire
